[rtl/core/rtpr_pkg.sv]
// Shared types, codes and helpers for the RTP reorder frame assembler.
`default_nettype none
package rtpr_pkg;

    // result kinds
    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_HELD   = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;
    localparam logic [1:0] KIND_EVICT  = 2'd3;

    // reject codes
    localparam logic [2:0] REJ_NONE    = 3'd0;
    localparam logic [2:0] REJ_LENGTH  = 3'd1;
    localparam logic [2:0] REJ_VERSION = 3'd2;
    localparam logic [2:0] REJ_PTYPE   = 3'd3;
    localparam logic [2:0] REJ_OLD     = 3'd4;
    localparam logic [2:0] REJ_DUP     = 3'd5;

    // register indexes
    localparam logic REG_CATCH_LIMIT = 1'b0;
    localparam logic REG_PTYPE       = 1'b1;

    localparam logic [4:0]  CATCH_LIMIT_RST  = 5'd31;
    localparam logic [6:0]  PTYPE_RST        = 7'd96;
    localparam logic [19:0] RTP_FIXED_BYTES  = 20'd12;
    localparam logic [19:0] WORD_BYTES       = 20'd4;
    localparam logic [1:0]  RTP_VERSION_TWO  = 2'd2;
    localparam int          RESULT_LIMIT     = 32;

    // one held packet
    typedef struct packed {
        logic [15:0] seq;
        logic        marker;
        logic        starts_ps;
        logic [7:0]  handle;
        logic [15:0] hdr_len;
        logic [15:0] pay_len;
    } t_slot;

    // store commands
    typedef struct packed {
        logic insert;
        logic pop;
    } t_slot_cmd;

    // 16-bit serial order: a comes before b
    function automatic logic precedes(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15];
    endfunction

endpackage
`default_nettype wire

[rtl/core/rtpr_slots.sv]
// Sorted packet store: shift-insert, pop from the front, one indexed read port.
`default_nettype none
module rtpr_slots #(
    parameter int CAPACITY = 32
) (
    input  wire                          i_clk,
    input  wire rtpr_pkg::t_slot_cmd     i_cmd,
    input  wire [$clog2(CAPACITY)-1:0]   i_ins_idx,
    input  wire rtpr_pkg::t_slot         i_wr,
    input  wire [$clog2(CAPACITY)-1:0]   i_rd_idx,
    output rtpr_pkg::t_slot              o_rd,
    output rtpr_pkg::t_slot              o_head
);
    import rtpr_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    t_slot r_slot [CAPACITY];

    assign o_rd   = r_slot[i_rd_idx];
    assign o_head = r_slot[0];

    // each entry takes the write word, its lower or its upper neighbour, or keeps its own
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_cmd.insert) begin
                if (IW'(g) == i_ins_idx) begin
                    r_slot[g] <= i_wr;
                end else if (g > 0 && IW'(g) > i_ins_idx) begin
                    r_slot[g] <= r_slot[(g > 0) ? g - 1 : 0];
                end
            end else if (i_cmd.pop && g < CAPACITY - 1) begin
                r_slot[g] <= r_slot[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/rtp_reorder_frame_assembler.sv]
// Top level: RTP packet word checks, reorder store and frame release sequencer.
// Input channel (i_valid/o_ready) takes one RTP packet descriptor word; output
// channel (o_valid/i_ready) gives result words, the final one of each input
// flagged by o_last_of_run. Registers sit on an APB-style port: catch limit
// at 0x0, accepted payload type at 0x4; write them only while idle.
// Per input word: a check state, a scan of the store for a duplicate and the
// insert point, an insert state, a walk along the front for a complete frame,
// a planning state, then the result words, one per cycle unless the receiver
// stalls. A rejected word leaves from the check or the scan state. The scan
// and the walk read the store through its single read port, one entry at a
// time; o_ready is high only when idle.
// Reset empties the store, clears the started flag and last released
// sequence, and restores the registers. A stalled receiver holds the output
// register; the sequencer waits on it and takes no new word until done.
`default_nettype none
module rtp_reorder_frame_assembler #(
    parameter int CAPACITY     = 32,
    parameter int HANDLE_WIDTH = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // packet descriptor channel
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [15:0] i_sequence_number,
    input  wire        i_marker_bit,
    input  wire [1:0]  i_rtp_version,
    input  wire [6:0]  i_payload_type,
    input  wire        i_padding_flag,
    input  wire        i_extension_flag,
    input  wire [3:0]  i_csrc_count,
    input  wire [15:0] i_extension_words,
    input  wire [7:0]  i_padding_count,
    input  wire [15:0] i_packet_length,
    input  wire        i_starts_ps_pack,
    input  wire [7:0]  i_packet_handle,
    // result channel
    output logic       o_valid,
    input  wire        i_ready,
    output logic [1:0] o_result_kind,
    output logic [2:0] o_reject_code,
    output logic [15:0] o_out_sequence,
    output logic [7:0] o_out_handle,
    output logic [15:0] o_header_length,
    output logic [15:0] o_payload_length,
    output logic       o_last_of_run,
    // register port
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import rtpr_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CAPM1 = ((CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT) - 1;
    localparam logic [7:0] HMASK = (HANDLE_WIDTH >= 8) ? 8'hFF
                                   : 8'((1 << HANDLE_WIDTH) - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHECK  = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_INSERT = 10'b0000001000,
        S_FRAME  = 10'b0000010000,
        S_PLAN   = 10'b0000100000,
        S_HELD   = 10'b0001000000,
        S_REL    = 10'b0010000000,
        S_EVICT  = 10'b0100000000,
        S_REJ    = 10'b1000000000
    } t_state;

    t_state r_state;

    // registers
    logic [4:0] r_catch_limit;
    logic [6:0] r_ptype_cfg;

    // captured input word
    logic [15:0] r_seq;
    logic        r_marker;
    logic [1:0]  r_version;
    logic [6:0]  r_ptype;
    logic        r_pflag;
    logic        r_xflag;
    logic [3:0]  r_cc;
    logic [15:0] r_ext;
    logic [7:0]  r_pad;
    logic [15:0] r_len;
    logic        r_ps;
    logic [7:0]  r_handle;

    logic [19:0] r_hdr;
    logic [2:0]  r_code;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_k;
    logic          r_found;
    logic [CW-1:0] r_rel;
    logic [CW-1:0] r_ev;
    logic [15:0]   r_flast;
    logic [15:0]   r_last_done;
    logic          r_started;

    // output register
    logic       r_ov;
    logic [1:0] r_kind;
    logic [2:0] r_ocode;
    logic [15:0] r_oseq;
    logic [7:0] r_ohandle;
    logic [15:0] r_ohdr;
    logic [15:0] r_opl;
    logic       r_olast;

    // store
    t_slot_cmd w_cmd;
    t_slot     w_wr;
    t_slot     w_rd;
    t_slot     w_head;

    rtpr_slots #(.CAPACITY(CAPACITY)) u_slots (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_ins_idx (r_k),
        .i_wr      (w_wr),
        .i_rd_idx  (r_idx[IW-1:0]),
        .o_rd      (w_rd),
        .o_head    (w_head)
    );

    // derived values
    logic [CW-1:0] w_lim;
    logic [19:0]   w_pad;
    logic [19:0]   w_hdr_next;
    logic [19:0]   w_pl;
    logic [CW-1:0] w_rem;
    logic          w_over;
    logic          w_gone;
    logic          w_out_free;
    logic          w_emit;
    logic          w_cfg_wr;

    assign w_lim = (r_catch_limit > 5'(CAPM1)) ? CW'(CAPM1) : CW'(r_catch_limit);
    assign w_pad = r_pflag ? 20'(r_pad) : 20'd0;
    assign w_hdr_next = RTP_FIXED_BYTES + WORD_BYTES * 20'(r_cc)
                      + (r_xflag ? (WORD_BYTES + WORD_BYTES * 20'(r_ext)) : 20'd0);
    assign w_pl  = 20'(r_len) - r_hdr - w_pad;
    assign w_rem = r_count - r_rel;
    assign w_over = w_rem > w_lim;
    assign w_gone = (CW'(r_k) < r_rel) || (w_over && (CW'(r_k) < r_count - w_lim));
    assign w_out_free = !r_ov || i_ready;
    assign w_emit = w_out_free && (r_state inside {S_HELD, S_REL, S_EVICT, S_REJ});
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign w_wr = '{seq: r_seq, marker: r_marker, starts_ps: r_ps, handle: r_handle,
                    hdr_len: r_hdr[15:0], pay_len: w_pl[15:0]};

    always_comb begin
        w_cmd.insert = (r_state == S_INSERT);
        w_cmd.pop    = ((r_state == S_REL) || (r_state == S_EVICT)) && w_out_free;
    end

    assign o_ready = (r_state == S_IDLE);
    assign pready  = 1'b1;

    // register read
    always_comb begin
        case (paddr[2])
            REG_CATCH_LIMIT: prdata = 32'(r_catch_limit);
            REG_PTYPE:       prdata = 32'(r_ptype_cfg);
            default:         prdata = 32'd0;
        endcase
    end

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_catch_limit <= CATCH_LIMIT_RST;
            r_ptype_cfg   <= PTYPE_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_CATCH_LIMIT) begin
                r_catch_limit <= pwdata[4:0];
            end else begin
                r_ptype_cfg <= pwdata[6:0];
            end
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_seq     <= i_sequence_number;
            r_marker  <= i_marker_bit;
            r_version <= i_rtp_version;
            r_ptype   <= i_payload_type;
            r_pflag   <= i_padding_flag;
            r_xflag   <= i_extension_flag;
            r_cc      <= i_csrc_count;
            r_ext     <= i_extension_words;
            r_pad     <= i_padding_count;
            r_len     <= i_packet_length;
            r_ps      <= i_starts_ps_pack;
            r_handle  <= i_packet_handle & HMASK;
        end
    end

    // output valid: set on a new result word, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_rel       <= '0;
            r_ev        <= '0;
            r_last_done <= 16'd0;
            r_started   <= 1'b0;
            r_code      <= REJ_NONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_hdr   <= w_hdr_next;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (20'(r_len) < RTP_FIXED_BYTES) begin
                        r_code  <= REJ_LENGTH;
                        r_state <= S_REJ;
                    end else if (r_ptype != r_ptype_cfg) begin
                        r_code  <= REJ_PTYPE;
                        r_state <= S_REJ;
                    end else if (r_started && precedes(r_seq, r_last_done)) begin
                        r_code  <= REJ_OLD;
                        r_state <= S_REJ;
                    end else if (r_started && r_seq == r_last_done) begin
                        r_code  <= REJ_DUP;
                        r_state <= S_REJ;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                // duplicate search and insert point, one entry a cycle
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        if (w_rd.seq == r_seq) begin
                            r_code  <= REJ_DUP;
                            r_state <= S_REJ;
                        end else if (!r_found && precedes(r_seq, w_rd.seq)) begin
                            r_found <= 1'b1;
                            r_k     <= r_idx[IW-1:0];
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        if (!r_found) begin
                            r_k <= r_count[IW-1:0];
                        end
                        if (20'(r_len) == RTP_FIXED_BYTES) begin
                            r_code  <= REJ_LENGTH;
                            r_state <= S_REJ;
                        end else if (r_version != RTP_VERSION_TWO) begin
                            r_code  <= REJ_VERSION;
                            r_state <= S_REJ;
                        end else if (r_hdr + w_pad > 20'(r_len)) begin
                            r_code  <= REJ_LENGTH;
                            r_state <= S_REJ;
                        end else begin
                            r_state <= S_INSERT;
                        end
                    end
                end
                S_INSERT: begin
                    r_count <= r_count + 1'b1;
                    r_idx   <= '0;
                    r_flast <= r_last_done;
                    r_rel   <= '0;
                    r_state <= S_FRAME;
                end
                // walk the front for a complete frame
                S_FRAME: begin
                    if (r_idx >= r_count) begin
                        r_state <= S_PLAN;
                    end else if (r_idx == '0 && !w_rd.starts_ps) begin
                        r_state <= S_PLAN;
                    end else if (r_idx == '0 && r_started && r_count < w_lim
                                 && (r_flast + 16'd1) != w_rd.seq) begin
                        r_state <= S_PLAN;
                    end else if (r_idx != '0 && (r_flast + 16'd1) != w_rd.seq) begin
                        r_state <= S_PLAN;
                    end else begin
                        r_flast <= w_rd.seq;
                        r_idx   <= r_idx + 1'b1;
                        if (w_rd.marker) begin
                            r_rel   <= r_idx + 1'b1;
                            r_state <= S_PLAN;
                        end
                    end
                end
                S_PLAN: begin
                    r_ev <= w_over ? (w_rem - w_lim) : '0;
                    if (!w_gone) begin
                        r_state <= S_HELD;
                    end else if (r_rel != '0) begin
                        r_state <= S_REL;
                    end else if (w_over) begin
                        r_state <= S_EVICT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_HELD: begin
                    if (w_out_free) begin
                        r_kind    <= KIND_HELD;
                        r_ocode   <= REJ_NONE;
                        r_oseq    <= r_seq;
                        r_ohandle <= r_handle;
                        r_ohdr    <= r_hdr[15:0];
                        r_opl     <= w_pl[15:0];
                        r_olast   <= (r_rel == '0) && (r_ev == '0);
                        if (r_rel != '0) begin
                            r_state <= S_REL;
                        end else if (r_ev != '0) begin
                            r_state <= S_EVICT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_REL: begin
                    if (w_out_free) begin
                        r_kind      <= KIND_FRAME;
                        r_ocode     <= REJ_NONE;
                        r_oseq      <= w_head.seq;
                        r_ohandle   <= w_head.handle;
                        r_ohdr      <= w_head.hdr_len;
                        r_opl       <= w_head.pay_len;
                        r_olast     <= (r_rel == CW'(1)) && (r_ev == '0);
                        r_last_done <= w_head.seq;
                        r_started   <= 1'b1;
                        r_count     <= r_count - 1'b1;
                        r_rel       <= r_rel - 1'b1;
                        if (r_rel == CW'(1)) begin
                            r_state <= (r_ev != '0) ? S_EVICT : S_IDLE;
                        end
                    end
                end
                S_EVICT: begin
                    if (w_out_free) begin
                        r_kind      <= KIND_EVICT;
                        r_ocode     <= REJ_NONE;
                        r_oseq      <= w_head.seq;
                        r_ohandle   <= w_head.handle;
                        r_ohdr      <= w_head.hdr_len;
                        r_opl       <= w_head.pay_len;
                        r_olast     <= (r_ev == CW'(1));
                        r_last_done <= w_head.seq;
                        r_count     <= r_count - 1'b1;
                        r_ev        <= r_ev - 1'b1;
                        if (r_ev == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_REJ: begin
                    if (w_out_free) begin
                        r_kind    <= KIND_REJECT;
                        r_ocode   <= r_code;
                        r_oseq    <= r_seq;
                        r_ohandle <= r_handle;
                        r_ohdr    <= 16'd0;
                        r_opl     <= 16'd0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_result_kind    = r_kind;
    assign o_reject_code    = r_ocode;
    assign o_out_sequence   = r_oseq;
    assign o_out_handle     = r_ohandle;
    assign o_header_length  = r_ohdr;
    assign o_payload_length = r_opl;
    assign o_last_of_run    = r_olast;

endmodule
`default_nettype wire
